// ===== design/bts_pkg.sv =====
package bts_pkg;

    localparam int EVENT_DEPTH_DEF = 64;

    localparam int DELAY_W  = 31;
    localparam int REMAIN_W = 17;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DELAY_W-1:0]  NO_EVENT_DELAY = 31'h4000_0000;
    localparam logic [REMAIN_W-1:0] ONE_SAMPLE     = 17'h1_0000;

    // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT, exact for x < 2**22
    localparam logic [22:0] DIV100_MAGIC = 23'd5368710;
    localparam int          DIV100_SHIFT = 29;

    localparam logic [4:0]  VOLUME_RESET = 5'd0;
    localparam logic [6:0]  MASTER_RESET = 7'd100;
    localparam logic [15:0] STEP_RESET   = 16'd0;

    typedef enum logic [1:0] {
        OP_QUEUE  = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME = 2'd0,
        CFG_MASTER = 2'd1,
        CFG_STEP   = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic queue;
        logic begin_empty;
        logic end_batch;
        logic pop;
        logic walk_init;
        logic walk_step;
        logic walk_end;
        logic tone;
        logic frac;
        logic scl1;
        logic scl2;
        logic clr_q;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic vol_zero;
        logic count_zero;
        logic pd_ge_one;
        logic remain_ge_pd;
        logic out_free;
    } t_stat;

endpackage

// ===== design/beeper_tone_sample_generator.sv =====
// Beeper tone sample generator, rate-generator mode.
// Input channel (i_in_valid / o_in_ready) takes one request per item:
//   queue an enable event, begin a batch, produce a sample, end a batch.
// Output channel (o_out_valid / i_out_ready) carries one signed 16-bit sample
//   per produce request; other requests give no sample.
// Config port: i_cfg_we with i_cfg_index 0 volume, 1 master volume, 2 tone
//   step; the user must write it only while the block is idle, which the
//   block itself does not enforce. A produced sample is valid from the cycle
//   input ready returns. Steps after acceptance: queue, end, begin on an empty
//   queue: none; begin with a queued event: pop; produce, volume zero: output;
//   tone case: tone, scaling, output; event walk: a walk and a pop per event
//   popped, a walk if the queue runs dry, a last walk, fraction, scaling, output.
// The event store is a single-port-read RAM read at the queue head; each pop
//   waits on its registered read. Scaling uses two registered multiplies.
// Only one request is in flight. The output register holds a finished sample
//   while the receiver stalls; further non-produce requests are still taken,
//   and a new produce waits in its final step until the register is free.
// Reset: queue empty, pending delay and level zero, tone off, phase zero,
//   volume 0, master volume 100, tone step 0. Store contents are not cleared.
module beeper_tone_sample_generator #(
    parameter int EVENT_DEPTH = bts_pkg::EVENT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_in_operation,
    input  logic [bts_pkg::DELAY_W-1:0]         i_in_event_delay,
    input  logic                                i_in_event_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bts_pkg::SAMPLE_W-1:0] o_out_sample,
    input  logic                                i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    bts_pkg::t_cmd  cmd;
    bts_pkg::t_stat stat;

    bts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_operation(i_in_operation),
        .i_stat        (stat),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    bts_dpath #(
        .EVENT_DEPTH(EVENT_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_event_delay(i_in_event_delay),
        .i_in_event_level(i_in_event_level),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_out_sample    (o_out_sample)
    );

endmodule

// ===== design/bts_ram.sv =====
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bts_ctrl.sv =====
module bts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_operation,
    input  bts_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output bts_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_BPOP = 9'b000000010,
        S_WALK = 9'b000000100,
        S_WPOP = 9'b000001000,
        S_TONE = 9'b000010000,
        S_FRAC = 9'b000100000,
        S_SCL1 = 9'b001000000,
        S_SCL2 = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (bts_pkg::t_op'(i_in_operation))
                        bts_pkg::OP_QUEUE: begin
                            o_cmd.queue = 1'b1;
                        end
                        bts_pkg::OP_BEGIN: begin
                            if (!i_stat.vol_zero) begin
                                if (i_stat.count_zero) begin
                                    o_cmd.begin_empty = 1'b1;
                                end else begin
                                    n_state = S_BPOP;
                                end
                            end
                        end
                        bts_pkg::OP_END: begin
                            o_cmd.end_batch = !i_stat.vol_zero;
                        end
                        bts_pkg::OP_SAMPLE: begin
                            if (i_stat.vol_zero) begin
                                o_cmd.clr_q = 1'b1;
                                n_state     = S_OUT;
                            end else if (i_stat.pd_ge_one) begin
                                n_state = S_TONE;
                            end else begin
                                o_cmd.walk_init = 1'b1;
                                n_state         = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_BPOP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.remain_ge_pd) begin
                    o_cmd.walk_step = 1'b1;
                    n_state = i_stat.count_zero ? S_WALK : S_WPOP;
                end else begin
                    o_cmd.walk_end = 1'b1;
                    n_state        = S_FRAC;
                end
            end
            S_WPOP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_WALK;
            end
            S_TONE: begin
                o_cmd.tone = 1'b1;
                n_state    = S_SCL1;
            end
            S_FRAC: begin
                o_cmd.frac = 1'b1;
                n_state    = S_SCL1;
            end
            S_SCL1: begin
                o_cmd.scl1 = 1'b1;
                n_state    = S_SCL2;
            end
            S_SCL2: begin
                o_cmd.scl2 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/bts_dpath.sv =====
module bts_dpath #(
    parameter int EVENT_DEPTH = bts_pkg::EVENT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bts_pkg::DELAY_W-1:0]         i_in_event_delay,
    input  logic                                i_in_event_level,
    input  logic                                i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_ready,
    input  bts_pkg::t_cmd                       i_cmd,
    output bts_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    output logic signed [bts_pkg::SAMPLE_W-1:0] o_out_sample
);

    localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int DW = bts_pkg::DELAY_W;
    localparam int RW = bts_pkg::REMAIN_W;
    localparam int SW = bts_pkg::SAMPLE_W;

    logic [4:0]    r_vol, n_vol;
    logic [6:0]    r_master, n_master;
    logic [15:0]   r_step, n_step;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_pd, n_pd;
    logic          r_pl, n_pl;
    logic          r_te, n_te;
    logic [15:0]   r_phase, n_phase;
    logic [RW-1:0] r_remain, n_remain;
    logic [RW-1:0] r_on, n_on;
    logic [SW-1:0] r_s, n_s;
    logic          r_neg, n_neg;
    logic [21:0]   r_mag, n_mag;
    logic [15:0]   r_q, n_q;
    logic          r_o_valid, n_o_valid;
    logic [SW-1:0] r_o_sample, n_o_sample;

    logic [CW:0]   slot_sum;
    logic [CW:0]   slot_wrap;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_inc;
    logic          count_full;
    logic          ram_we;
    logic [31:0]   ram_rdata;

    logic [15:0]        p1, p2, p3, p4;
    logic [2:0]         ones;
    logic signed [4:0]  tone_sum;
    logic signed [10:0] tone_prod;
    logic [SW-1:0]      tone_val;
    logic [21:0]        frac_prod;
    logic [SW-1:0]      frac_val;
    logic [SW-1:0]      s_abs;
    logic [44:0]        div_prod;

    assign slot_sum  = {{(CW + 1 - AW){1'b0}}, r_head} + {1'b0, r_count};
    assign slot_wrap = (slot_sum >= (CW + 1)'(EVENT_DEPTH)) ?
                       slot_sum - (CW + 1)'(EVENT_DEPTH) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];
    assign head_inc  = (r_head == AW'(EVENT_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign count_full = (r_count == CW'(EVENT_DEPTH));
    assign ram_we    = i_cmd.queue && !count_full;

    bts_ram #(
        .WIDTH(32),
        .DEPTH(EVENT_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(slot),
        .i_wdata({i_in_event_level, i_in_event_delay}),
        .i_raddr(r_head),
        .o_rdata(ram_rdata)
    );

    // four quarter-sample phase steps
    assign p1   = r_phase + r_step;
    assign p2   = p1 + r_step;
    assign p3   = p2 + r_step;
    assign p4   = p3 + r_step;
    assign ones = 3'(r_phase[15]) + 3'(p1[15]) + 3'(p2[15]) + 3'(p3[15]);
    assign tone_sum  = $signed({1'b0, ones, 1'b0}) - 5'sd4;
    assign tone_prod = 11'(tone_sum) * 11'($signed({1'b0, r_vol}));
    assign tone_val  = {tone_prod[7:0], 8'h00};

    assign frac_prod = 22'(r_on) * 22'(r_vol);
    assign frac_val  = frac_prod[21:6];

    assign s_abs    = r_s[SW-1] ? SW'(-r_s) : r_s;
    assign div_prod = 45'(r_mag) * 45'(bts_pkg::DIV100_MAGIC);

    always_comb begin
        o_stat.vol_zero     = (r_vol == '0);
        o_stat.count_zero   = (r_count == '0);
        o_stat.pd_ge_one    = (r_pd >= DW'(bts_pkg::ONE_SAMPLE));
        o_stat.remain_ge_pd = (DW'(r_remain) >= r_pd);
        o_stat.out_free     = !r_o_valid || i_out_ready;
    end

    always_comb begin
        n_vol      = r_vol;
        n_master   = r_master;
        n_step     = r_step;
        n_head     = r_head;
        n_count    = r_count;
        n_pd       = r_pd;
        n_pl       = r_pl;
        n_te       = r_te;
        n_phase    = r_phase;
        n_remain   = r_remain;
        n_on       = r_on;
        n_s        = r_s;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_q        = r_q;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_sample = r_o_sample;

        if (i_cfg_we) begin
            unique case (bts_pkg::t_cfg_idx'(i_cfg_index))
                bts_pkg::CFG_VOLUME: n_vol    = i_cfg_data[4:0];
                bts_pkg::CFG_MASTER: n_master = i_cfg_data[6:0];
                bts_pkg::CFG_STEP:   n_step   = i_cfg_data;
                bts_pkg::CFG_NONE:   n_step   = r_step;
            endcase
        end

        if (ram_we) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.begin_empty) begin
            n_pd = bts_pkg::NO_EVENT_DELAY;
            n_pl = r_te;
        end
        if (i_cmd.end_batch) begin
            n_te    = r_pl;
            n_count = '0;
            n_head  = '0;
        end
        if (i_cmd.pop) begin
            n_pd    = ram_rdata[DW-1:0];
            n_pl    = ram_rdata[31];
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end
        if (i_cmd.walk_init) begin
            n_remain = bts_pkg::ONE_SAMPLE;
            n_on     = '0;
        end
        if (i_cmd.walk_step) begin
            n_remain = r_remain - r_pd[RW-1:0];
            if (r_te) begin
                n_on = r_on + r_pd[RW-1:0];
            end
            n_te    = r_pl;
            n_phase = '0;
            if (r_count == '0) begin
                n_pd = bts_pkg::NO_EVENT_DELAY;
            end
        end
        if (i_cmd.walk_end) begin
            n_pd = r_pd - DW'(r_remain);
            if (r_te) begin
                n_on = r_on + r_remain;
            end
        end
        if (i_cmd.tone) begin
            n_pd = r_pd - DW'(bts_pkg::ONE_SAMPLE);
            if (r_te) begin
                n_phase = p4;
                n_s     = tone_val;
            end else begin
                n_s = '0;
            end
        end
        if (i_cmd.frac) begin
            n_s = frac_val[SW-1] ? '0 : frac_val;
        end
        if (i_cmd.scl1) begin
            n_neg = r_s[SW-1];
            n_mag = 22'(s_abs) * 22'(r_master);
        end
        if (i_cmd.scl2) begin
            n_q = div_prod[bts_pkg::DIV100_SHIFT +: 16];
        end
        if (i_cmd.clr_q) begin
            n_q   = '0;
            n_neg = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_o_valid  = 1'b1;
            n_o_sample = r_neg ? SW'(-r_q) : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol     <= bts_pkg::VOLUME_RESET;
            r_master  <= bts_pkg::MASTER_RESET;
            r_step    <= bts_pkg::STEP_RESET;
            r_head    <= '0;
            r_count   <= '0;
            r_pd      <= '0;
            r_pl      <= 1'b0;
            r_te      <= 1'b0;
            r_phase   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_vol     <= n_vol;
            r_master  <= n_master;
            r_step    <= n_step;
            r_head    <= n_head;
            r_count   <= n_count;
            r_pd      <= n_pd;
            r_pl      <= n_pl;
            r_te      <= n_te;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain   <= n_remain;
        r_on       <= n_on;
        r_s        <= n_s;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_q        <= n_q;
        r_o_sample <= n_o_sample;
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_sample = $signed(r_o_sample);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(EVENT_DEPTH))
        else $error("event count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(EVENT_DEPTH - 1))
        else $error("event head out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from empty event queue");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_o_valid)
        else $error("loaded sample not presented");

endmodule
